// ===== rtl/assert_macros.svh =====
// Assertion macros used by the command post deframer RTL (the result queue).
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define CPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/cpd_pkg.sv =====
// Package for the command post deframer: payload structs, result codes and parser phases.
// No dependencies.
`timescale 1ns / 1ps

package cpd_pkg;

  localparam logic [31:0] MagicReset = 32'h1145_1419;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_START  = 3'd1,
    KIND_CHAR   = 3'd2,
    KIND_END    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_BUSY     = 2'd0,
    STATUS_FINISH   = 2'd1,
    STATUS_CONTINUE = 2'd2,
    STATUS_FAIL     = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_HEAD  = 8'b0000_0010,
    PH_COUNT = 8'b0000_0100,
    PH_CONT  = 8'b0000_1000,
    PH_MAGIC = 8'b0001_0000,
    PH_TYPE  = 8'b0010_0000,
    PH_TEXT  = 8'b0100_0000,
    PH_DEAD  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] head_word;
    logic [31:0] command_count;
    logic        continue_flag;
    logic [31:0] command_index;
    logic [31:0] command_type;
    logic [7:0]  text_char;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // Compact result record between parser and output stage.
  // word_a: head word, type word or character; word_b: command count.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic        last;
    logic        cont;
    logic [31:0] index;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } event_t;

endpackage

// ===== rtl/command_post_deframer.sv =====
// Command post deframer, top level.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one byte of a post
// per request; first_byte marks the start of a post and restarts the parser.
// Output channel (out_valid_o / out_ready_i / out_data_o) gives header,
// command start, command character, command end and error results; the last
// result of a post has last set and a finish, continue or fail status.
// magic_we_i / magic_wdata_i write the expected command magic word; write it
// only while no post is in flight.
// Throughput: one byte per cycle while the result queue is not full; the parser
// state is registered on each accepted byte. A result is written into the queue
// by the parser, then popped from the queue into the output register.
// Stall: the result queue (QueueDepth entries) and the output register absorb
// a stalled receiver; in_ready_o drops once the queue is full.
// Reset: parser idle, queue and output register empty, magic word 0x11451419.
// Uses cpd_pkg, cpd_front, cpd_queue and cpd_back.
`timescale 1ns / 1ps

module command_post_deframer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          magic_we_i,
  input  logic [31:0]   magic_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cpd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cpd_pkg::out_t out_data_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  cpd_pkg::event_t push_ev;
  cpd_pkg::event_t pop_ev;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  cpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .magic_we_i    (magic_we_i),
    .magic_wdata_i (magic_wdata_i),
    .accept_i      (accept),
    .in_i          (in_data_i),
    .push_o        (push),
    .ev_o          (push_ev)
  );

  cpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_ev),
    .pop_i   (pop),
    .data_o  (pop_ev),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_ev),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/cpd_front.sv =====
// Parser front end: assembles little-endian words, tracks the post phase and
// classifies each accepted byte into at most one result record. Uses cpd_pkg.
`timescale 1ns / 1ps

module cpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             magic_we_i,
  input  logic [31:0]      magic_wdata_i,
  input  logic             accept_i,
  input  cpd_pkg::in_t     in_i,
  output logic             push_o,
  output cpd_pkg::event_t  ev_o
);

  cpd_pkg::phase_e phase_q, phase_d;
  logic [1:0]      pos_q, pos_d;
  logic [31:0]     shift_q, shift_d;
  logic [31:0]     head_q, head_d;
  logic [31:0]     count_q, count_d;
  logic [31:0]     done_q, done_d;
  logic            cont_q, cont_d;
  logic [31:0]     magic_q;

  cpd_pkg::phase_e eff_phase;
  logic [1:0]      eff_pos;
  logic [31:0]     eff_shift;
  logic [31:0]     eff_done;
  logic [31:0]     new_shift;
  logic [31:0]     done_inc;
  logic            full;
  logic            emit;
  cpd_pkg::status_e end_status;

  always_comb begin
    // A first byte restarts the post whatever the current phase.
    eff_phase  = in_i.first_byte ? cpd_pkg::PH_HEAD : phase_q;
    eff_pos    = in_i.first_byte ? 2'd0 : pos_q;
    eff_shift  = in_i.first_byte ? 32'd0 : shift_q;
    eff_done   = in_i.first_byte ? 32'd0 : done_q;
    new_shift  = {in_i.data_byte, eff_shift[31:8]};
    full       = (eff_pos == 2'd3);
    done_inc   = eff_done + 32'd1;
    end_status = cont_q ? cpd_pkg::STATUS_CONTINUE : cpd_pkg::STATUS_FINISH;

    phase_d = eff_phase;
    pos_d   = eff_pos;
    shift_d = eff_shift;
    head_d  = head_q;
    count_d = count_q;
    done_d  = eff_done;
    cont_d  = cont_q;
    emit    = 1'b0;
    ev_o    = '0;

    case (eff_phase)
      cpd_pkg::PH_HEAD: begin
        shift_d = new_shift;
        pos_d   = eff_pos + 2'd1;
        if (full) begin
          head_d  = new_shift;
          phase_d = cpd_pkg::PH_COUNT;
        end
      end
      cpd_pkg::PH_COUNT: begin
        shift_d = new_shift;
        pos_d   = eff_pos + 2'd1;
        if (full) begin
          count_d = new_shift;
          phase_d = cpd_pkg::PH_CONT;
        end
      end
      cpd_pkg::PH_CONT: begin
        cont_d      = (in_i.data_byte != 8'd0);
        done_d      = 32'd0;
        pos_d       = 2'd0;
        emit        = 1'b1;
        ev_o.kind   = cpd_pkg::KIND_HEADER;
        ev_o.word_a = head_q;
        ev_o.word_b = count_q;
        ev_o.cont   = cont_d;
        if (count_q == 32'd0) begin
          ev_o.status = cont_d ? cpd_pkg::STATUS_CONTINUE : cpd_pkg::STATUS_FINISH;
          ev_o.last   = 1'b1;
          phase_d     = cpd_pkg::PH_IDLE;
        end else begin
          phase_d = cpd_pkg::PH_MAGIC;
        end
      end
      cpd_pkg::PH_MAGIC: begin
        shift_d = new_shift;
        pos_d   = eff_pos + 2'd1;
        if (full) begin
          if (new_shift != magic_q) begin
            emit        = 1'b1;
            ev_o.kind   = cpd_pkg::KIND_ERROR;
            ev_o.index  = eff_done;
            ev_o.status = cpd_pkg::STATUS_FAIL;
            ev_o.last   = 1'b1;
            phase_d     = cpd_pkg::PH_DEAD;
          end else begin
            phase_d = cpd_pkg::PH_TYPE;
          end
        end
      end
      cpd_pkg::PH_TYPE: begin
        shift_d = new_shift;
        pos_d   = eff_pos + 2'd1;
        if (full) begin
          emit        = 1'b1;
          ev_o.kind   = cpd_pkg::KIND_START;
          ev_o.index  = eff_done;
          ev_o.word_a = new_shift;
          phase_d     = cpd_pkg::PH_TEXT;
        end
      end
      cpd_pkg::PH_TEXT: begin
        emit       = 1'b1;
        ev_o.index = eff_done;
        if (in_i.data_byte != 8'd0) begin
          ev_o.kind   = cpd_pkg::KIND_CHAR;
          ev_o.word_a = {24'd0, in_i.data_byte};
        end else begin
          ev_o.kind = cpd_pkg::KIND_END;
          done_d    = done_inc;
          if (done_inc == count_q) begin
            ev_o.status = end_status;
            ev_o.last   = 1'b1;
            phase_d     = cpd_pkg::PH_IDLE;
          end else begin
            phase_d = cpd_pkg::PH_MAGIC;
            pos_d   = 2'd0;
          end
        end
      end
      default: begin
        // Idle or dead: drop the byte.
      end
    endcase
  end

  assign push_o = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= cpd_pkg::MagicReset;
    end else if (magic_we_i) begin
      magic_q <= magic_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cpd_pkg::PH_IDLE;
      pos_q   <= 2'd0;
      shift_q <= 32'd0;
      head_q  <= 32'd0;
      count_q <= 32'd0;
      done_q  <= 32'd0;
      cont_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
      cont_q  <= cont_d;
    end
  end

endmodule

// ===== rtl/cpd_queue.sv =====
// Short result queue between the parser and the output stage.
// Stores cpd_pkg::event_t records; uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cpd_pkg::event_t data_i,
  input  logic            pop_i,
  output cpd_pkg::event_t data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cpd_pkg::event_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  `CPD_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full result queue")
  `CPD_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from empty result queue")
  `CPD_ASSERT(a_push_holds, (push_i && !pop_i) |=> !empty_o, "queue empty after a push")
  `CPD_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "queue count beyond depth")

endmodule

// ===== rtl/cpd_back.sv =====
// Output stage: pops result records from the queue and expands them into the
// full result payload held in an output register. Uses cpd_pkg.
`timescale 1ns / 1ps

module cpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  cpd_pkg::event_t q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cpd_pkg::out_t   out_data_o
);

  logic          valid_q;
  cpd_pkg::out_t data_q, data_d;

  assign q_pop_o = !q_empty_i && (!valid_q || out_ready_i);

  always_comb begin
    data_d               = '0;
    data_d.kind          = q_data_i.kind;
    data_d.command_index = q_data_i.index;
    data_d.status        = q_data_i.status;
    data_d.last          = q_data_i.last;
    case (q_data_i.kind)
      cpd_pkg::KIND_HEADER: begin
        data_d.head_word     = q_data_i.word_a;
        data_d.command_count = q_data_i.word_b;
        data_d.continue_flag = q_data_i.cont;
      end
      cpd_pkg::KIND_START: data_d.command_type = q_data_i.word_a;
      cpd_pkg::KIND_CHAR:  data_d.text_char    = q_data_i.word_a[7:0];
      default: begin
        // End and error results carry index, status and last only.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
